// ===== sv/segmented_memory_decoder_assert.svh =====
// ----------------------------------------------------------------------------
// segmented_memory_decoder_assert.svh
// assertion macros used by the segmented memory decoder datapath
// ----------------------------------------------------------------------------
`ifndef SEGMENTED_MEMORY_DECODER_ASSERT_SVH
`define SEGMENTED_MEMORY_DECODER_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define SMD_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition never holds
`define SMD_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

// ===== sv/smd_pkg.sv =====
// ----------------------------------------------------------------------------
// smd_pkg
// types and constants of the segmented memory decoder
// ----------------------------------------------------------------------------
`default_nettype none

package smd_pkg;

    localparam int NUM_SEGMENTS = 4;
    localparam int SEG_W        = 2;
    localparam int NUM_REGS     = 2 * NUM_SEGMENTS;
    localparam int APB_ADDR_W   = 5;
    localparam int DATA_W       = 32;

    // access commands
    localparam logic [1:0] CMD_READ_BYTE  = 2'd0;
    localparam logic [1:0] CMD_READ_WORD  = 2'd1;
    localparam logic [1:0] CMD_WRITE_BYTE = 2'd2;
    localparam logic [1:0] CMD_WRITE_WORD = 2'd3;

    // fault codes
    localparam logic [1:0] FAULT_OK       = 2'd0;
    localparam logic [1:0] FAULT_UNMAPPED = 2'd1;
    localparam logic [1:0] FAULT_BEYOND   = 2'd2;

    // one address window, inclusive bounds
    typedef struct packed {
        logic [DATA_W-1:0] base;
        logic [DATA_W-1:0] limit;
    } smd_window_t;

    // controller to datapath
    typedef struct packed {
        logic clear_en;
        logic load_req;
        logic decode;
        logic check;
        logic access;
        logic load_rsp;
    } smd_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clear_done;
        logic rsp_free;
    } smd_status_t;

endpackage

`default_nettype wire

// ===== sv/smd_req_if.sv =====
// ----------------------------------------------------------------------------
// smd_req_if
// access request channel: command, address and write data
// ----------------------------------------------------------------------------
`default_nettype none

interface smd_req_if import smd_pkg::*; ();

    logic              valid;
    logic              ready;
    logic [1:0]        command;
    logic [DATA_W-1:0] address;
    logic [DATA_W-1:0] write_data;

    modport source (output valid, output command, output address, output write_data,
                    input ready);
    modport sink   (input valid, input command, input address, input write_data,
                    output ready);

endinterface

`default_nettype wire

// ===== sv/smd_rsp_if.sv =====
// ----------------------------------------------------------------------------
// smd_rsp_if
// access response channel: read data and fault code
// ----------------------------------------------------------------------------
`default_nettype none

interface smd_rsp_if import smd_pkg::*; ();

    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] read_data;
    logic [1:0]        fault;

    modport source (output valid, output read_data, output fault, input ready);
    modport sink   (input valid, input read_data, input fault, output ready);

endinterface

`default_nettype wire

// ===== sv/smd_apb_regs.sv =====
// ----------------------------------------------------------------------------
// smd_apb_regs
// apb register file holding the base and limit of the four windows
// ----------------------------------------------------------------------------
`default_nettype none

module smd_apb_regs import smd_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0]     pwdata,
    output logic      [DATA_W-1:0]     prdata,
    output logic                       pready,
    output smd_window_t [NUM_SEGMENTS-1:0] windows
);

    localparam int IDX_W = APB_ADDR_W - 2;

    logic [DATA_W-1:0] cfg_reg [NUM_REGS];
    logic [IDX_W-1:0]  reg_idx;
    logic              wr_en;

    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign prdata  = cfg_reg[reg_idx];

    // register writes on the access phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
            begin
                cfg_reg[i] <= '0;
            end
        end
        else if (wr_en)
        begin
            cfg_reg[reg_idx] <= pwdata;
        end
    end

    // even index is the base, odd index the limit
    always_comb
    begin
        for (int s = 0; s < NUM_SEGMENTS; s++)
        begin
            windows[s].base  = cfg_reg[2*s];
            windows[s].limit = cfg_reg[2*s+1];
        end
    end

endmodule

`default_nettype wire

// ===== sv/smd_ctrl.sv =====
// ----------------------------------------------------------------------------
// smd_ctrl
// sequencer: clearing pass, then accept, decode, check, access, respond
// ----------------------------------------------------------------------------
`default_nettype none

module smd_ctrl import smd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire smd_status_t status,
    output smd_cmd_t         cmd
);

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_DECODE = 3'd2;
    localparam logic [2:0] ST_CHECK  = 3'd3;
    localparam logic [2:0] ST_ACCESS = 3'd4;
    localparam logic [2:0] ST_RESP   = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:  if (status.clear_done) state_next = ST_IDLE;
            ST_IDLE:   if (in_valid) state_next = ST_DECODE;
            ST_DECODE: state_next = ST_CHECK;
            ST_CHECK:  state_next = ST_ACCESS;
            ST_ACCESS: state_next = ST_RESP;
            ST_RESP:   if (status.rsp_free) state_next = ST_IDLE;
            default:   state_next = ST_CLEAR;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // datapath commands
    assign in_ready     = (state_reg == ST_IDLE);
    assign cmd.clear_en = (state_reg == ST_CLEAR);
    assign cmd.load_req = in_ready && in_valid;
    assign cmd.decode   = (state_reg == ST_DECODE);
    assign cmd.check    = (state_reg == ST_CHECK);
    assign cmd.access   = (state_reg == ST_ACCESS);
    assign cmd.load_rsp = (state_reg == ST_RESP) && status.rsp_free;

endmodule

`default_nettype wire

// ===== sv/smd_datapath.sv =====
// ----------------------------------------------------------------------------
// smd_datapath
// window decode, bounds check, four byte banks and the response register
// ----------------------------------------------------------------------------
`default_nettype none

`include "segmented_memory_decoder_assert.svh"

module smd_datapath import smd_pkg::*;
#(
    parameter int SEGMENT_BYTES = 4096
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire smd_cmd_t                  cmd,
    output smd_status_t                    status,
    input  wire smd_window_t [NUM_SEGMENTS-1:0] windows,
    input  wire logic [1:0]                req_command,
    input  wire logic [DATA_W-1:0]         req_address,
    input  wire logic [DATA_W-1:0]         req_write_data,
    smd_rsp_if.source                      rsp
);

    // one row holds four bytes, one per bank; the store has SEGMENT_BYTES rows
    localparam int ROW_W  = $clog2(SEGMENT_BYTES);
    localparam int GIDX_W = ROW_W + 2;

    // captured request
    logic [1:0]        cmd_reg;
    logic [DATA_W-1:0] addr_reg;
    logic [DATA_W-1:0] wdata_reg;

    // decode and check results
    logic [SEG_W-1:0]  seg_reg;
    logic              mapped_reg;
    logic [DATA_W-1:0] offset_reg;
    logic [1:0]        fault_reg;
    logic [GIDX_W-1:0] gidx_reg;

    logic [ROW_W-1:0]  clear_cnt_reg;

    logic              rsp_valid_reg;
    logic [DATA_W-1:0] rsp_data_reg;
    logic [1:0]        rsp_fault_reg;

    logic                     is_word;
    logic                     is_write;
    logic [NUM_SEGMENTS-1:0]  hit;
    logic [SEG_W-1:0]         seg_next;
    logic [DATA_W-1:0]        offset_next;
    logic [DATA_W-1:0]        last_offset;
    logic [1:0]               fault_next;
    logic [GIDX_W-1:0]        gidx_next;
    logic [3:0]               bank_we;
    logic [3:0][7:0]          bank_rd;
    logic [3:0][7:0]          rd_word;
    logic [DATA_W-1:0]        read_data_next;

    assign is_word  = (cmd_reg == CMD_READ_WORD) || (cmd_reg == CMD_WRITE_WORD);
    assign is_write = (cmd_reg == CMD_WRITE_BYTE) || (cmd_reg == CMD_WRITE_WORD);

    // capture the accepted item
    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            cmd_reg   <= req_command;
            addr_reg  <= req_address;
            wdata_reg <= req_write_data;
        end
    end

    // window match, first hit in priority order
    always_comb
    begin
        seg_next = '0;
        for (int s = 0; s < NUM_SEGMENTS; s++)
        begin
            hit[s] = (addr_reg >= windows[s].base) && (addr_reg <= windows[s].limit);
        end
        for (int s = NUM_SEGMENTS - 1; s >= 0; s--)
        begin
            if (hit[s])
            begin
                seg_next = SEG_W'(s);
            end
        end
    end

    assign offset_next = addr_reg - windows[seg_next].base;

    always_ff @(posedge clk)
    begin
        if (cmd.decode)
        begin
            seg_reg    <= seg_next;
            mapped_reg <= |hit;
            offset_reg <= offset_next;
        end
    end

    // bounds check and global byte index
    assign last_offset = is_word ? DATA_W'(SEGMENT_BYTES - 4) : DATA_W'(SEGMENT_BYTES - 1);

    always_comb
    begin
        if (!mapped_reg)
        begin
            fault_next = FAULT_UNMAPPED;
        end
        else if (offset_reg > last_offset)
        begin
            fault_next = FAULT_BEYOND;
        end
        else
        begin
            fault_next = FAULT_OK;
        end
    end

    assign gidx_next = GIDX_W'(GIDX_W'(seg_reg) * GIDX_W'(SEGMENT_BYTES))
                     + offset_reg[GIDX_W-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.check)
        begin
            fault_reg <= fault_next;
            gidx_reg  <= gidx_next;
        end
    end

    // clearing pass counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_cnt_reg <= '0;
        end
        else if (cmd.clear_en)
        begin
            clear_cnt_reg <= clear_cnt_reg + 1'b1;
        end
    end

    assign status.clear_done = (clear_cnt_reg == ROW_W'(SEGMENT_BYTES - 1));

    // byte banks: bank b holds global bytes with index mod 4 equal to b
    for (genvar b = 0; b < 4; b++)
    begin : g_bank
        logic [7:0]       mem [SEGMENT_BYTES];
        logic [7:0]       rd_q;
        logic [1:0]       lane;
        logic             lane_en;
        logic             wrap;
        logic             re;
        logic [ROW_W-1:0] row;
        logic [ROW_W-1:0] bank_addr;
        logic [7:0]       bank_wdata;

        assign lane       = 2'(b) - gidx_reg[1:0];
        assign lane_en    = is_word || (lane == 2'd0);
        assign wrap       = (2'(b) < gidx_reg[1:0]);
        assign row        = gidx_reg[GIDX_W-1:2] + {{(ROW_W-1){1'b0}}, wrap};
        assign bank_we[b] = cmd.clear_en
                          || (cmd.access && (fault_reg == FAULT_OK) && is_write && lane_en);
        assign re         = cmd.access && (fault_reg == FAULT_OK) && !is_write && lane_en;
        assign bank_addr  = cmd.clear_en ? clear_cnt_reg : row;
        assign bank_wdata = cmd.clear_en ? 8'h00 : wdata_reg[{lane, 3'b000} +: 8];

        always_ff @(posedge clk)
        begin
            if (bank_we[b])
            begin
                mem[bank_addr] <= bank_wdata;
            end
            if (re)
            begin
                rd_q <= mem[bank_addr];
            end
        end

        assign bank_rd[b] = rd_q;
    end

    // reorder bank outputs into little-endian byte lanes
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            rd_word[i] = bank_rd[2'(i) + gidx_reg[1:0]];
        end
    end

    always_comb
    begin
        if ((fault_reg != FAULT_OK) || is_write)
        begin
            read_data_next = '0;
        end
        else if (is_word)
        begin
            read_data_next = rd_word;
        end
        else
        begin
            read_data_next = {24'h000000, rd_word[0]};
        end
    end

    // response register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (cmd.load_rsp)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_rsp)
        begin
            rsp_data_reg  <= read_data_next;
            rsp_fault_reg <= fault_reg;
        end
    end

    assign status.rsp_free = !rsp_valid_reg || rsp.ready;
    assign rsp.valid       = rsp_valid_reg;
    assign rsp.read_data   = rsp_data_reg;
    assign rsp.fault       = rsp_fault_reg;

    // checks
    `SMD_ASSERT_IMPLIES(a_fault_zero_data, rsp_valid_reg && (rsp_fault_reg != FAULT_OK), rsp_data_reg == '0, "faulted response carries data")
    `SMD_ASSERT_IMPLIES(a_fault_no_write, cmd.access && (fault_reg != FAULT_OK), bank_we == 4'b0000, "faulted access writes a bank")
    `SMD_ASSERT_IMPLIES(a_write_lanes, cmd.access && (fault_reg == FAULT_OK) && is_write, is_word ? (bank_we == 4'b1111) : $onehot(bank_we), "wrong bank enables on write")
    `SMD_ASSERT_NEVER(a_clear_vs_access, cmd.clear_en && (cmd.access || cmd.load_req), "access during clearing pass")

endmodule

`default_nettype wire

// ===== sv/segmented_memory_decoder.sv =====
// ----------------------------------------------------------------------------
// segmented_memory_decoder
// address window decoder with four byte-addressed segment stores
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over all SEGMENT_BYTES rows, one row of
// four byte banks per cycle, before it takes its first item; apb writes are taken
// during the pass. Each item then passes through accept, window decode, bounds
// check, bank access and response load; the sequencer steps through one stage per
// cycle, holding in response load until the output register is free, and handles
// one item at a time. A response waiting in the output register does not block
// acceptance of the next item, only the response load.
`default_nettype none

module segmented_memory_decoder import smd_pkg::*;
#(
    parameter int SEGMENT_BYTES = 4096
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0]     pwdata,
    output logic      [DATA_W-1:0]     prdata,
    output logic                       pready,
    smd_req_if.sink                    req,
    smd_rsp_if.source                  rsp
);

    smd_window_t [NUM_SEGMENTS-1:0] windows;
    smd_cmd_t                       cmd;
    smd_status_t                    status;
    logic                           in_ready;

    // window registers
    smd_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .windows (windows)
    );

    // sequencer
    smd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    assign req.ready = in_ready;

    // decode, banks and response
    smd_datapath #(
        .SEGMENT_BYTES (SEGMENT_BYTES)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .windows        (windows),
        .req_command    (req.command),
        .req_address    (req.address),
        .req_write_data (req.write_data),
        .rsp            (rsp)
    );

endmodule

`default_nettype wire

// ===== tb/tb_segmented_memory_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_segmented_memory_decoder
// self-checking bench for the segmented memory decoder
// ----------------------------------------------------------------------------
// Programs the four address windows over the apb port and drives byte and
// word accesses into the request channel. A scoreboard keeps its own window
// registers and byte stores, predicts read data and fault code for every
// accepted item, and compares each response against the oldest prediction.
// Stimulus is a directed opener followed by random phases across several
// window layouts (disjoint, overlapping, empty, tiny) and idling modes.
// ----------------------------------------------------------------------------

module tb_segmented_memory_decoder;

    import smd_pkg::*;

    localparam int SEG_BYTES       = 4096;
    localparam int ITEMS_PER_PHASE = 222;
    localparam int NUM_PHASES      = 8;
    localparam int HOLD_CYCLES     = 300;
    localparam int SETTLE_CYCLES   = 8;
    localparam int WATCHDOG_NS     = 1000000;

    // expected response of one access
    typedef struct {
        logic [DATA_W-1:0] read_data;
        logic [1:0]        fault;
    } access_result_t;

    // window map and byte stores, predicted responses in order
    class access_scoreboard;
        bit [7:0]       seg_store [NUM_SEGMENTS][SEG_BYTES];
        bit [31:0]      win_base  [NUM_SEGMENTS];
        bit [31:0]      win_limit [NUM_SEGMENTS];
        access_result_t awaited   [$];
        int             mismatches;

        function void set_register(int idx, bit [31:0] value);
            if (idx % 2 == 0)
                win_base[idx / 2] = value;
            else
                win_limit[idx / 2] = value;
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        // decode, bounds check and store access for one accepted item
        function void note_access(logic [1:0] command, logic [31:0] address,
                                  logic [31:0] wdata);
            access_result_t    r;
            int                seg;
            int                nbytes;
            bit                is_write;
            bit [31:0]         offset;
            longint unsigned   last_end;
            r.read_data = '0;
            r.fault     = FAULT_OK;
            seg         = -1;
            // lowest index wins among overlapping windows
            for (int s = NUM_SEGMENTS - 1; s >= 0; s--) begin
                if (address >= win_base[s] && address <= win_limit[s])
                    seg = s;
            end
            nbytes   = (command == CMD_READ_WORD || command == CMD_WRITE_WORD) ? 4 : 1;
            is_write = (command == CMD_WRITE_BYTE || command == CMD_WRITE_WORD);
            if (seg < 0) begin
                r.fault = FAULT_UNMAPPED;
            end
            else begin
                offset   = address - win_base[seg];
                last_end = offset;
                last_end += nbytes;
                if (last_end > SEG_BYTES) begin
                    r.fault = FAULT_BEYOND;
                end
                else begin
                    // little-endian, all bytes in the segment of the first byte
                    for (int i = 0; i < nbytes; i++) begin
                        if (is_write)
                            seg_store[seg][offset + i] = wdata[8*i +: 8];
                        else
                            r.read_data[8*i +: 8] = seg_store[seg][offset + i];
                    end
                end
            end
            awaited.push_back(r);
        endfunction

        task report_mismatch(string what);
            mismatches++;
            if (mismatches <= 100)
                $display("[%0t] mismatch: %s", $time, what);
        endtask

        task check_response(logic [31:0] rd, logic [1:0] ft);
            access_result_t want;
            if (awaited.size() == 0) begin
                report_mismatch($sformatf("response %08h/%0d with no item pending", rd, ft));
                return;
            end
            want = awaited.pop_front();
            if (rd !== want.read_data)
                report_mismatch($sformatf("read_data got %08h, want %08h",
                                          rd, want.read_data));
            if (ft !== want.fault)
                report_mismatch($sformatf("fault got %0d, want %0d", ft, want.fault));
        endtask
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [DATA_W-1:0]     pwdata;
    logic [DATA_W-1:0]     prdata;
    logic                  pready;

    smd_req_if req_ch ();
    smd_rsp_if rsp_ch ();

    access_scoreboard sb;

    int        idle_pct;
    int        stall_pct;
    int        hold_requests;
    bit        hold_active;
    bit [31:0] recent_addrs [$];

    // window layouts: disjoint, overlapping, empty windows, tiny windows
    bit [31:0] window_plan [4][NUM_REGS] = '{
        '{32'h7fff_f000, 32'h7fff_ffff, 32'h0040_0000, 32'h0040_00ff,
          32'h1001_0000, 32'h1001_1fff, 32'hffff_f000, 32'hffff_ffff},
        '{32'h0000_1000, 32'h0000_1fff, 32'h0000_1800, 32'h0000_2fff,
          32'h0000_0000, 32'h0000_3fff, 32'h0000_0000, 32'hffff_ffff},
        '{32'hffff_ffff, 32'h0000_0000, 32'h0000_0000, 32'h0000_0fff,
          32'hffff_fffc, 32'hffff_ffff, 32'h0000_0005, 32'h0000_0004},
        '{32'h0000_2000, 32'h0000_2000, 32'hffff_fff0, 32'hffff_ffff,
          32'h0000_1ffc, 32'h0000_2003, 32'h8000_0000, 32'h8000_0fff}
    };

    segmented_memory_decoder #(
        .SEGMENT_BYTES (SEG_BYTES)
    ) u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .req     (req_ch),
        .rsp     (rsp_ch)
    );

    // clock
    initial clk = 1'b0;
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // accepted items feed the predictor
    always @(posedge clk)
    begin
        if (rst_n && req_ch.valid && req_ch.ready)
            sb.note_access(req_ch.command, req_ch.address, req_ch.write_data);
    end

    // accepted responses are checked in order
    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
            sb.check_response(rsp_ch.read_data, rsp_ch.fault);
    end

    // long receiver hold-off, counted here
    initial
    begin
        int served;
        served      = 0;
        hold_active = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_requests != served) begin
                served = hold_requests;
                hold_active <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_active <= 1'b0;
            end
        end
    end

    // response ready with random stalls
    initial
    begin
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            rsp_ch.ready <= !hold_active && ($urandom_range(99) >= stall_pct);
        end
    end

    // watchdog
    initial
    begin
        #(WATCHDOG_NS);
        $display("FAILURE");
        $finish;
    end

    // one apb register write, setup then access
    task apb_write(int idx, bit [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'(idx * 4);
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_register(idx, value);
        @(posedge clk);
    endtask

    task load_setting(int k);
        for (int i = 0; i < NUM_REGS; i++)
            apb_write(i, window_plan[k][i]);
    endtask

    // offer one item, with random idle cycles ahead of it
    task send_item(logic [1:0] cmd, bit [31:0] addr, bit [31:0] data);
        while ($urandom_range(99) < idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.command    <= cmd;
        req_ch.address    <= addr;
        req_ch.write_data <= data;
        do @(posedge clk); while (!req_ch.ready);
    endtask

    // wait on the clock first so the last accepted item is already counted
    task wait_drain();
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // mostly addresses inside open windows, revisiting recent ones
    function automatic bit [31:0] pick_address();
        bit [31:0] a;
        bit [31:0] span;
        int        s;
        int        tries;
        int        roll;
        roll = $urandom_range(99);
        if (roll < 10)
            return $urandom();
        if (roll < 45 && recent_addrs.size() > 0)
            return recent_addrs[$urandom_range(recent_addrs.size() - 1)]
                   + $urandom_range(6) - 3;
        s     = $urandom_range(NUM_SEGMENTS - 1);
        tries = 0;
        while (tries < NUM_SEGMENTS && sb.win_base[s] > sb.win_limit[s]) begin
            s = (s + 1) % NUM_SEGMENTS;
            tries++;
        end
        if (tries == NUM_SEGMENTS)
            return $urandom();
        span = sb.win_limit[s] - sb.win_base[s];
        // near the end of the store, or anywhere in the first 4100 bytes of the window
        if (roll < 60)
            a = sb.win_base[s] + SEG_BYTES - 6 + $urandom_range(9);
        else
            a = sb.win_base[s] + ((span < 4100) ? $urandom_range(span) : $urandom_range(4099));
        recent_addrs.push_back(a);
        if (recent_addrs.size() > 32)
            void'(recent_addrs.pop_front());
        return a;
    endfunction

    // main sequence
    initial
    begin
        int mode;
        sb                = new();
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        req_ch.valid      = 1'b0;
        req_ch.command    = CMD_READ_BYTE;
        req_ch.address    = '0;
        req_ch.write_data = '0;
        idle_pct          = 0;
        stall_pct         = 0;
        hold_requests     = 0;
        rst_n             = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed opener on the disjoint layout
        load_setting(0);
        send_item(CMD_READ_BYTE,  32'h7fff_f000, 32'h0);          // cleared store
        send_item(CMD_WRITE_WORD, 32'h7fff_f000, 32'hdead_beef);
        send_item(CMD_READ_WORD,  32'h7fff_f000, 32'h0);
        send_item(CMD_READ_BYTE,  32'h7fff_f001, 32'h0);
        send_item(CMD_WRITE_BYTE, 32'h0040_0000, 32'hffff_ffa5);  // low byte only
        send_item(CMD_READ_WORD,  32'h0040_0000, 32'h0);
        send_item(CMD_WRITE_WORD, 32'h0040_00fe, 32'h8765_4321);  // word past limit
        send_item(CMD_READ_WORD,  32'h0040_00fe, 32'h0);
        send_item(CMD_READ_BYTE,  32'h0040_0100, 32'h0);          // unmapped
        send_item(CMD_WRITE_WORD, 32'h1001_0001, 32'h0102_0304);  // unaligned
        send_item(CMD_READ_WORD,  32'h1001_0001, 32'h0);
        send_item(CMD_READ_BYTE,  32'h1001_0004, 32'h0);
        send_item(CMD_WRITE_BYTE, 32'h1001_0fff, 32'h0000_00ff);  // last store byte
        send_item(CMD_WRITE_WORD, 32'h1001_0ffd, 32'hffff_ffff);  // runs off the store
        send_item(CMD_READ_BYTE,  32'h1001_0ffd, 32'h0);
        send_item(CMD_READ_BYTE,  32'h1001_1000, 32'h0);          // in window, off store
        send_item(CMD_WRITE_WORD, 32'hffff_fffc, 32'h55aa_55aa);  // top of address space
        send_item(CMD_READ_WORD,  32'hffff_fffc, 32'h0);
        send_item(CMD_READ_WORD,  32'hffff_fffd, 32'h0);
        send_item(CMD_READ_BYTE,  32'hffff_ffff, 32'h0);
        send_item(CMD_READ_WORD,  32'h0000_0000, 32'h0);
        send_item(CMD_WRITE_BYTE, 32'h0000_0000, 32'hffff_ffff);
        send_item(CMD_WRITE_WORD, 32'h7fff_effc, 32'hffff_ffff);  // just below stack
        req_ch.valid <= 1'b0;

        // random phases across layouts and idling modes
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            wait_drain();
            load_setting(phase % 4);
            mode = (phase + phase / 4) % 4;
            case (mode)
                0: begin idle_pct = 0;  stall_pct <= 0;  end
                1: begin idle_pct = 50; stall_pct <= 0;  end
                2: begin idle_pct = 0;  stall_pct <= 50; end
                default: begin idle_pct = 10; stall_pct <= 10; end
            endcase
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                // receiver holds off while items keep coming
                if (phase == 0 && n == 40)
                    hold_requests <= hold_requests + 1;
                // sender pauses until the block has answered everything
                if (phase == 2 && n == 100) begin
                    req_ch.valid <= 1'b0;
                    wait_drain();
                end
                send_item(2'($urandom_range(3)), pick_address(), $urandom());
            end
            req_ch.valid <= 1'b0;
        end

        wait_drain();
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/smd_pkg.sv
sv/smd_req_if.sv
sv/smd_rsp_if.sv
sv/smd_apb_regs.sv
sv/smd_ctrl.sv
sv/smd_datapath.sv
sv/segmented_memory_decoder.sv
tb/tb_segmented_memory_decoder.sv
